// ===== hdl/fpa_pkg.sv =====
// fixed-point alu package: constants, action codes, register indexes and pipeline types
// no dependencies; used by every module of the fixed-point alu core
package fpa_pkg;

   localparam int MAX_WIDTH      = 32;
   localparam int DATA_W         = 32;
   localparam int RAD_W          = 2 * DATA_W;
   localparam int REM_W          = DATA_W + 4;
   localparam int BITS_PER_STAGE = 4;
   localparam int SQRT_STAGES    = DATA_W / BITS_PER_STAGE;
   localparam int ADDR_W         = 4;

   typedef enum logic [3:0] {
      ACT_ADD     = 4'd0,
      ACT_SUB     = 4'd1,
      ACT_NEG     = 4'd2,
      ACT_MUL     = 4'd3,
      ACT_SHR     = 4'd4,
      ACT_SHL     = 4'd5,
      ACT_COMPARE = 4'd6,
      ACT_ABSDIFF = 4'd7,
      ACT_SQRT    = 4'd8
   } action_type;

   localparam logic [1:0] REG_IS_SIGNED    = 2'd0;
   localparam logic [1:0] REG_WIDTH_SELECT = 2'd1;
   localparam logic [1:0] REG_FRAC_BITS    = 2'd2;

   typedef struct packed {
      logic                valid;
      logic                use_root;
      logic [DATA_W-1:0]   result;
      logic                lt;
      logic                eq;
      logic [DATA_W-1:0]   mask;
      logic [REM_W-1:0]    rem;
      logic [DATA_W-1:0]   root;
      logic [RAD_W-1:0]    rad;
   } sq_type;

   // a few digits of the restoring square root, two radicand bits per digit
   function automatic sq_type sqrt_step(sq_type s);
      sq_type           t;
      logic [REM_W-1:0] trial;
      t = s;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         t.rem = {t.rem[REM_W-3:0], t.rad[RAD_W-1:RAD_W-2]};
         t.rad = {t.rad[RAD_W-3:0], 2'b00};
         trial = {2'b00, t.root, 2'b01};
         if (t.rem >= trial) begin
            t.rem  = t.rem - trial;
            t.root = {t.root[DATA_W-2:0], 1'b1};
         end else begin
            t.root = {t.root[DATA_W-2:0], 1'b0};
         end
      end
      return t;
   endfunction

endpackage

// ===== hdl/fixed_point_alu_core.sv =====
// fixed-point alu top level: stream channels, register port and pipeline stall control
// depends on fpa_pkg, fpa_front and fpa_sqrt
//
//   channel  | direction | handshake         | payload
//   req      | in        | tvalid / tready   | action, operand_a, operand_b, shift_amount
//   rsp      | out       | tvalid / tready   | result_bits, a_less, a_equal
//   csr      | in/out    | psel / penable    | is_signed, width_select, frac_bits
//
// one transaction per cycle while rsp is not stalled; four front stages and eight
// root stages of four bits each, the root digit chain setting the depth
// the last root stage is the output register; the whole pipeline holds while
// it holds a result and rsp_tready is low, and bubbles are not squeezed out
// synchronous reset clears the valid bits and loads the register defaults
module fixed_point_alu_core
   import fpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [79:0]       req_tdata,   // action, operand_a, operand_b, shift_amount
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // result_bits, a_less, a_equal
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic       is_signed_ff;
   logic [1:0] width_select_ff;
   logic [5:0] frac_bits_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_signed_ff    <= 1'b1;
         width_select_ff <= 2'd2;
         frac_bits_ff    <= 6'd15;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_IS_SIGNED:    is_signed_ff    <= csr_pwdata[0];
            REG_WIDTH_SELECT: width_select_ff <= csr_pwdata[1:0];
            REG_FRAC_BITS:    frac_bits_ff    <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_IS_SIGNED:    csr_prdata = {31'd0, is_signed_ff};
         REG_WIDTH_SELECT: csr_prdata = {30'd0, width_select_ff};
         REG_FRAC_BITS:    csr_prdata = {26'd0, frac_bits_ff};
         default:          csr_prdata = '0;
      endcase
   end

   logic   en;
   sq_type front_out, last;

   assign en         = ~last.valid | rsp_tready;
   assign req_tready = en;

   fpa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_tvalid),
      .action       (req_tdata[3:0]),
      .operand_a    (req_tdata[35:4]),
      .operand_b    (req_tdata[67:36]),
      .shift_amount (req_tdata[72:68]),
      .is_signed    (is_signed_ff),
      .width_select (width_select_ff),
      .frac_bits    (frac_bits_ff),
      .out          (front_out)
   );

   fpa_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_stage  (front_out),
      .out_stage (last)
   );

   logic [DATA_W-1:0] result_bits;

   assign result_bits = (last.use_root ? last.root : last.result) & last.mask;
   assign rsp_tvalid  = last.valid;
   assign rsp_tdata   = {6'd0, last.eq, last.lt, result_bits};

`ifndef NO_ASSERTIONS
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[32] && rsp_tdata[33]))
      else $error("a_less and a_equal both set");

   a_compare_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[32] || rsp_tdata[33]) |-> rsp_tdata[31:0] == 32'd0)
      else $error("compare result carries nonzero bits");

   a_stall_ctrl: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready disagrees with output stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

// ===== hdl/fpa_front.sv =====
// fixed-point alu front pipeline: format decode, simple operations, multiply and rounding
// depends on fpa_pkg; feeds fpa_sqrt
module fpa_front
   import fpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [3:0]        action,
   input  logic [DATA_W-1:0] operand_a,
   input  logic [DATA_W-1:0] operand_b,
   input  logic [4:0]        shift_amount,
   input  logic              is_signed,
   input  logic [1:0]        width_select,
   input  logic [5:0]        frac_bits,
   output sq_type            out
);

   // stage 1: decoded format and masked operands
   logic              v1_ff;
   action_type        act1_ff;
   logic [DATA_W-1:0] a1_ff, b1_ff, mask1_ff;
   logic [4:0]        sh1_ff;
   logic [4:0]        msb1_ff;
   logic [5:0]        f1_ff;
   logic              sgn1_ff;

   logic [5:0]        w_in, fmax_in, f_in;
   logic [DATA_W-1:0] mask_in;

   always_comb begin
      case (width_select)
         2'd0:    w_in = 6'd8;
         2'd1:    w_in = 6'd16;
         default: w_in = 6'd32;
      endcase
      if (w_in > 6'(MAX_WIDTH)) w_in = 6'(MAX_WIDTH);
      fmax_in = w_in - {5'd0, is_signed};
      f_in    = (frac_bits == 6'd0) ? 6'd1 : frac_bits;
      if (f_in > fmax_in) f_in = fmax_in;
      mask_in = {DATA_W{1'b1}} >> (6'd32 - w_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         act1_ff  <= action_type'(action);
         a1_ff    <= operand_a & mask_in;
         b1_ff    <= operand_b & mask_in;
         sh1_ff   <= shift_amount;
         mask1_ff <= mask_in;
         msb1_ff  <= 5'(w_in - 6'd1);
         f1_ff    <= f_in;
         sgn1_ff  <= is_signed;
      end
   end

   // stage 2: simple results, compare, magnitude product, radicand
   logic              v2_ff, lt2_ff, eq2_ff, neg2_ff, sqz2_ff;
   action_type        act2_ff;
   logic [DATA_W-1:0] r2_ff, mask2_ff;
   logic [RAD_W-1:0]  prod2_ff, rad2_ff;
   logic [5:0]        f2_ff;

   logic              sa, sb, a_lt_b, b_lt_a;
   logic [DATA_W:0]   ea, eb, shr_full;
   logic [DATA_W-1:0] ma, mb, r_in;

   always_comb begin
      sa       = sgn1_ff & a1_ff[msb1_ff];
      sb       = sgn1_ff & b1_ff[msb1_ff];
      ea       = sa ? {1'b1, a1_ff | ~mask1_ff} : {1'b0, a1_ff};
      eb       = sb ? {1'b1, b1_ff | ~mask1_ff} : {1'b0, b1_ff};
      a_lt_b   = $signed(ea) < $signed(eb);
      b_lt_a   = $signed(eb) < $signed(ea);
      ma       = sa ? ((~a1_ff + 1'b1) & mask1_ff) : a1_ff;
      mb       = sb ? ((~b1_ff + 1'b1) & mask1_ff) : b1_ff;
      shr_full = $signed(ea) >>> sh1_ff;
      case (act1_ff)
         ACT_ADD:     r_in = a1_ff + b1_ff;
         ACT_SUB:     r_in = a1_ff - b1_ff;
         ACT_NEG:     r_in = DATA_W'(0) - a1_ff;
         ACT_SHR:     r_in = shr_full[DATA_W-1:0];
         ACT_SHL:     r_in = a1_ff << sh1_ff;
         ACT_ABSDIFF: r_in = b_lt_a ? (a1_ff - b1_ff) : (b1_ff - a1_ff);
         default:     r_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         act2_ff  <= act1_ff;
         r2_ff    <= r_in & mask1_ff;
         lt2_ff   <= (act1_ff == ACT_COMPARE) & a_lt_b;
         eq2_ff   <= (act1_ff == ACT_COMPARE) & (a1_ff == b1_ff);
         prod2_ff <= RAD_W'(ma) * RAD_W'(mb);
         neg2_ff  <= sa ^ sb;
         sqz2_ff  <= sa;
         f2_ff    <= f1_ff;
         mask2_ff <= mask1_ff;
         rad2_ff  <= {{DATA_W{1'b0}}, a1_ff} << f1_ff;
      end
   end

   // stage 3: rounding and scaling of the product
   logic              v3_ff, lt3_ff, eq3_ff, neg3_ff, sqz3_ff;
   action_type        act3_ff;
   logic [DATA_W-1:0] r3_ff, mask3_ff, p3_ff;
   logic [RAD_W-1:0]  rad3_ff, rounded, scaled;

   always_comb begin
      rounded = prod2_ff;
      if (f2_ff > 6'd8) rounded = prod2_ff + (RAD_W'(1) << (f2_ff - 6'd1));
      scaled = rounded >> f2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         act3_ff  <= act2_ff;
         r3_ff    <= r2_ff;
         lt3_ff   <= lt2_ff;
         eq3_ff   <= eq2_ff;
         neg3_ff  <= neg2_ff;
         sqz3_ff  <= sqz2_ff;
         mask3_ff <= mask2_ff;
         p3_ff    <= scaled[DATA_W-1:0] & mask2_ff;
         rad3_ff  <= rad2_ff;
      end
   end

   // stage 4: sign restore and operation select
   sq_type out_ff, out_in;

   always_comb begin
      out_in          = '0;
      out_in.valid    = v3_ff;
      out_in.lt       = lt3_ff;
      out_in.eq       = eq3_ff;
      out_in.mask     = mask3_ff;
      out_in.use_root = (act3_ff == ACT_SQRT) & ~sqz3_ff;
      out_in.rad      = out_in.use_root ? rad3_ff : '0;
      if (act3_ff == ACT_MUL) begin
         out_in.result = neg3_ff ? ((DATA_W'(0) - p3_ff) & mask3_ff) : p3_ff;
      end else begin
         out_in.result = r3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign out = out_ff;

endmodule

// ===== hdl/fpa_sqrt.sv =====
// fixed-point alu square root pipeline: four root bits per stage, other results ride along
// depends on fpa_pkg; fed by fpa_front
module fpa_sqrt
   import fpa_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   en,
   input  sq_type in_stage,
   output sq_type out_stage
);

   sq_type stage_ff [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      sq_type src;
      if (k == 0) begin : g_first
         assign src = in_stage;
      end else begin : g_rest
         assign src = stage_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else if (en) begin
            stage_ff[k] <= sqrt_step(src);
         end
      end
   end

   assign out_stage = stage_ff[SQRT_STAGES-1];

endmodule
